/* src/smk_pkg.sv */
package smk_pkg;

    localparam int DIMS = 4;
    localparam int NUM_REGS = 3 + DIMS;
    localparam int IDX_W = $clog2(NUM_REGS + 1);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_MODE = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_TAU2 = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_NUG  = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_INV0 = IDX_W'(3);

    // Smoothness codes
    localparam logic [1:0] MODE_05 = 2'd0;
    localparam logic [1:0] MODE_15 = 2'd1;
    localparam logic [1:0] MODE_25 = 2'd2;

    // Lane product: |d|^2 (34 bits) * inv (16 bits)
    localparam int LANE_W = 50;
    localparam int ACC_W  = LANE_W + $clog2(DIMS) + 3;
    localparam int TAYLOR_TERMS = 12;
    localparam int SQUARINGS = 8;

endpackage

/* src/smk_lane.sv */
// One dimension of the distance: difference, square, scale by inverse lengthscale.
module smk_lane (
    input  logic                        i_clk,
    input  logic signed [15:0]          i_a,
    input  logic signed [15:0]          i_b,
    input  logic [15:0]                 i_inv,
    output logic [smk_pkg::LANE_W-1:0]  o_term
);
    logic [16:0] r_ad;
    logic [15:0] r_inv;
    logic [33:0] r_sq;
    logic [15:0] r_inv2;
    logic signed [16:0] w_d;

    assign w_d = 17'(i_a) - 17'(i_b);

    always_ff @(posedge i_clk) begin
        r_ad   <= w_d[16] ? 17'(-w_d) : 17'(w_d);
        r_inv  <= i_inv;
        r_sq   <= 34'(r_ad) * 34'(r_ad);
        r_inv2 <= r_inv;
        o_term <= smk_pkg::LANE_W'(r_sq) * smk_pkg::LANE_W'(r_inv2);
    end
endmodule

/* src/smk_sqrt.sv */
// Pipelined integer square root of a 48-bit value, one result bit per stage.
module smk_sqrt (
    input  logic                i_clk,
    input  logic [47:0]         i_v,
    output logic [23:0]         o_root
);
    localparam int IN_W = 48;
    localparam int OW = IN_W / 2;
    logic [IN_W-1:0] r_rem  [OW+1];
    logic [OW-1:0]   r_res  [OW+1];

    always_comb begin
        r_rem[0] = i_v;
        r_res[0] = '0;
    end

    for (genvar g = 0; g < OW; g++) begin : g_stage
        localparam int B = OW - 1 - g;
        logic [IN_W+1:0] w_trial;
        assign w_trial = ((IN_W+2)'(r_res[g]) << (B + 1)) + ((IN_W+2)'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if ((IN_W+2)'(r_rem[g]) >= w_trial) begin
                r_rem[g+1] <= IN_W'((IN_W+2)'(r_rem[g]) - w_trial);
                r_res[g+1] <= r_res[g] | (OW'(1) << B);
            end else begin
                r_rem[g+1] <= r_rem[g];
                r_res[g+1] <= r_res[g];
            end
        end
    end

    assign o_root = r_res[OW];
endmodule

/* src/smk_exp.sv */
// Pipelined exp(-s): Taylor terms, each a multiply stage then a divide stage, then a clamp and eight squarings.
module smk_exp (
    input  logic        i_clk,
    input  logic [23:0] i_s,
    output logic [31:0] o_e
);
    localparam int T = smk_pkg::TAYLOR_TERMS;
    logic [31:0]        r_t   [T+1];
    logic signed [35:0] r_sum [T+1];
    logic [23:0]        r_s   [T+1];
    logic [55:0]        r_p   [T];
    logic signed [35:0] r_psum[T];
    logic [23:0]        r_ps  [T];

    always_comb begin
        r_t[0]   = 32'h8000_0000;
        r_sum[0] = 36'sh0_8000_0000;
        r_s[0]   = i_s;
    end

    for (genvar k = 1; k <= T; k++) begin : g_term
        // floor(v / k) as a reciprocal multiply, exact for any 32-bit v
        localparam int L = $clog2(k);
        localparam logic [32:0] M = 33'(((65'd1 << (32 + L)) + 65'(k) - 65'd1) / 65'(k));
        logic [31:0] w_t;
        logic [65:0] w_q;
        always_ff @(posedge i_clk) begin
            r_p[k-1]    <= 56'(r_t[k-1]) * 56'(r_s[k-1]);
            r_psum[k-1] <= r_sum[k-1];
            r_ps[k-1]   <= r_s[k-1];
        end
        assign w_q = 66'(r_p[k-1][55:24]) * 66'(M);
        assign w_t = 32'(w_q >> (32 + L));
        always_ff @(posedge i_clk) begin
            r_t[k]   <= w_t;
            r_sum[k] <= (k % 2 == 1) ? r_psum[k-1] - 36'(w_t) : r_psum[k-1] + 36'(w_t);
            r_s[k]   <= r_ps[k-1];
        end
    end

    logic [31:0] r_e [smk_pkg::SQUARINGS+1];
    always_ff @(posedge i_clk) begin
        if (r_sum[T] < 0)
            r_e[0] <= '0;
        else if (r_sum[T] > 36'sh0_8000_0000)
            r_e[0] <= 32'h8000_0000;
        else
            r_e[0] <= 32'(r_sum[T]);
    end
    for (genvar q = 0; q < smk_pkg::SQUARINGS; q++) begin : g_sq
        logic [63:0] w_sq;
        assign w_sq = 64'(r_e[q]) * 64'(r_e[q]);
        always_ff @(posedge i_clk) r_e[q+1] <= 32'(w_sq >> 31);
    end
    assign o_e = r_e[smk_pkg::SQUARINGS];
endmodule

/* src/separable_matern_kernel.sv */
// Separable Matern covariance kernel. Raise start with a pair of points
// (and i_on_diagonal) in any cycle; busy is held low, so one request is
// taken every cycle. Each request yields one result on o_covariance and
// o_saturated, marked by a single-cycle o_valid, once the request has
// passed 3 lane stages, 3 for merge, smoothness scale and clip, a 24-stage
// square root, 1 + 33 for the exponential and 3 to combine. The receiver
// cannot stall: sample the result in the cycle o_valid is high. Configuration
// may be written only while no request is in flight.
module separable_matern_kernel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [smk_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [15:0]                   i_cfg_data,
    input  logic signed [15:0]            i_first_coord_0,
    input  logic signed [15:0]            i_first_coord_1,
    input  logic signed [15:0]            i_first_coord_2,
    input  logic signed [15:0]            i_first_coord_3,
    input  logic signed [15:0]            i_second_coord_0,
    input  logic signed [15:0]            i_second_coord_1,
    input  logic signed [15:0]            i_second_coord_2,
    input  logic signed [15:0]            i_second_coord_3,
    input  logic                          i_on_diagonal,
    output logic                          o_valid,
    output logic [23:0]                   o_covariance,
    output logic                          o_saturated
);
    localparam int D = smk_pkg::DIMS;
    localparam int LAT_LANE = 3;
    localparam int LAT_SQRT = 24;
    localparam int LAT_EXP  = 2 * smk_pkg::TAYLOR_TERMS + 1 + smk_pkg::SQUARINGS;
    // lanes, merge + scale + clip, sqrt, exp input, exp, P*E, *tau2, final
    localparam int LAT = LAT_LANE + 3 + LAT_SQRT + 1 + LAT_EXP + 3;

    logic [1:0]  r_mode;
    logic [15:0] r_tau2, r_nug;
    logic [15:0] r_inv [D];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= smk_pkg::MODE_05;
            r_tau2 <= 16'd256;
            r_nug  <= '0;
            for (int k = 0; k < D; k++) r_inv[k] <= 16'd4096;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == smk_pkg::REG_MODE) r_mode <= i_cfg_data[1:0];
            if (i_cfg_idx == smk_pkg::REG_TAU2) r_tau2 <= i_cfg_data;
            if (i_cfg_idx == smk_pkg::REG_NUG)  r_nug  <= i_cfg_data;
            for (int k = 0; k < D; k++)
                if (i_cfg_idx == smk_pkg::REG_INV0 + smk_pkg::IDX_W'(k))
                    r_inv[k] <= i_cfg_data;
        end
    end

    assign busy = 1'b0;

    logic signed [15:0] w_a [D];
    logic signed [15:0] w_b [D];
    assign w_a[0] = i_first_coord_0;  assign w_b[0] = i_second_coord_0;
    assign w_a[1] = i_first_coord_1;  assign w_b[1] = i_second_coord_1;
    assign w_a[2] = i_first_coord_2;  assign w_b[2] = i_second_coord_2;
    assign w_a[3] = i_first_coord_3;  assign w_b[3] = i_second_coord_3;

    logic [smk_pkg::LANE_W-1:0] w_term [D];
    for (genvar k = 0; k < D; k++) begin : g_lane
        smk_lane u_lane (.i_clk(i_clk), .i_a(w_a[k]), .i_b(w_b[k]),
                         .i_inv(r_inv[k]), .o_term(w_term[k]));
    end

    // Valid and diagonal flag travel alongside the datapath.
    logic [LAT-2:0] r_vld, r_diag;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[LAT-3:0], start};
        r_diag <= {r_diag[LAT-3:0], i_on_diagonal};
    end

    // Merge the lanes, then scale by the smoothness factor.
    logic [smk_pkg::ACC_W-1:0] r_acc, r_acc3;
    always_ff @(posedge i_clk) begin
        r_acc <= smk_pkg::ACC_W'(w_term[0]) + smk_pkg::ACC_W'(w_term[1])
               + smk_pkg::ACC_W'(w_term[2]) + smk_pkg::ACC_W'(w_term[3]);
        case (r_mode)
            smk_pkg::MODE_15: r_acc3 <= r_acc + (r_acc << 1);
            smk_pkg::MODE_25: r_acc3 <= r_acc + (r_acc << 2);
            default:          r_acc3 <= r_acc;
        endcase
    end

    // Clip R to 32 bits.
    logic [31:0] r_r;
    logic        r_rsat;
    logic [smk_pkg::ACC_W-21:0] w_rfull;
    assign w_rfull = r_acc3[smk_pkg::ACC_W-1:20];
    always_ff @(posedge i_clk) begin
        r_rsat <= |w_rfull[smk_pkg::ACC_W-21:32];
        r_r    <= (|w_rfull[smk_pkg::ACC_W-21:32]) ? 32'hFFFF_FFFF : w_rfull[31:0];
    end

    logic [23:0] w_s;
    smk_sqrt u_sqrt (.i_clk(i_clk), .i_v({r_r, 16'h0}), .o_root(w_s));

    // Carry R and the saturation flag alongside the square root.
    logic [31:0] r_rd [LAT_SQRT];
    logic        r_sd [LAT_SQRT];
    logic [31:0] r_r3;
    always_ff @(posedge i_clk) begin
        r_rd[0] <= r_r; r_sd[0] <= r_rsat;
        for (int i = 1; i < LAT_SQRT; i++) begin
            r_rd[i] <= r_rd[i-1]; r_sd[i] <= r_sd[i-1];
        end
        // floor(R/3) by reciprocal multiply, ready with the root
        r_r3 <= 32'((64'(r_rd[LAT_SQRT-2]) * 64'h0000_0000_AAAA_AAAB) >> 33);
    end

    // Polynomial factor P, built once per request and delayed across exp.
    logic [33:0] w_p;
    always_comb begin
        case (r_mode)
            smk_pkg::MODE_15: w_p = 34'h1_0000 + 34'(w_s);
            smk_pkg::MODE_25: w_p = 34'h1_0000 + 34'(w_s) + 34'(r_r3);
            default:          w_p = 34'h1_0000;
        endcase
    end

    logic [33:0] r_pd [LAT_EXP+1];
    logic        r_se [LAT_EXP+1];
    always_ff @(posedge i_clk) begin
        r_pd[0] <= w_p; r_se[0] <= r_sd[LAT_SQRT-1];
        for (int i = 1; i < LAT_EXP + 1; i++) begin
            r_pd[i] <= r_pd[i-1]; r_se[i] <= r_se[i-1];
        end
    end

    logic [31:0] w_e;
    logic [23:0] r_sin;
    always_ff @(posedge i_clk) r_sin <= w_s;
    smk_exp u_exp (.i_clk(i_clk), .i_s(r_sin), .o_e(w_e));

    // Combine: E*P, then tau2, then nugget and clip.
    logic [34:0] r_ep;
    logic [50:0] r_v;
    logic        r_s1, r_s2;
    logic [31:0] r_nt;
    logic [51:0] w_v;
    always_ff @(posedge i_clk) begin
        r_ep <= 35'((66'(w_e) * 66'(r_pd[LAT_EXP])) >> 31);
        r_s1 <= r_se[LAT_EXP];
        r_v  <= 51'((51'(r_ep) * 51'(r_tau2)) >> 8);
        r_s2 <= r_s1;
        r_nt <= 32'(r_tau2) * 32'(r_nug);
    end
    assign w_v = 52'(r_v) + (r_diag[LAT-2] ? 52'(r_nt >> 8) : 52'd0);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r_vld[LAT-2];
        o_covariance <= (|w_v[51:24]) ? 24'hFF_FFFF : w_v[23:0];
        o_saturated  <= r_s2 | (|w_v[51:24]);
    end
endmodule

/* src/smk_checker.sv */
module smk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [23:0] o_covariance,
    input logic        o_saturated
);
    // cycles from a taken request to its result strobe
    localparam int LAT = 67;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LAT o_valid)
        else $error("result missing after request");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_covariance, o_saturated}))
        else $error("unknown result");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result straight after reset");
endmodule

bind separable_matern_kernel smk_checker u_chk (.*);
